// ===== rtl/utf8v_pkg.sv =====
// ============================================================================
// UTF-8 stream validator package
// Shared types, error codes and byte-class constants for the validator.
// ============================================================================
package utf8v_pkg;

    // First-error codes reported with every result.
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_CONTROL   = 3'd1,
        ERR_LEAD      = 3'd2,
        ERR_CONT      = 3'd3,
        ERR_RANGE     = 3'd4,
        ERR_TRUNCATED = 3'd5
    } t_err;

    // Sequence length classes (number of continuation bytes).
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_TWO   = 2'd1;
    localparam logic [1:0] CLS_THREE = 2'd2;
    localparam logic [1:0] CLS_FOUR  = 2'd3;

    // Byte ranges and code point limits.
    localparam logic [7:0]  BYTE_TAB       = 8'h09;
    localparam logic [7:0]  BYTE_LF        = 8'h0a;
    localparam logic [7:0]  BYTE_CR        = 8'h0d;
    localparam logic [7:0]  BYTE_SPACE     = 8'h20;
    localparam logic [1:0]  CONT_TAG       = 2'b10;
    localparam logic [20:0] CP_MIN_TWO     = 21'h000080;
    localparam logic [20:0] CP_MIN_THREE   = 21'h000800;
    localparam logic [20:0] CP_MIN_FOUR    = 21'h010000;
    localparam logic [20:0] CP_MAX         = 21'h10ffff;
    localparam logic [20:0] CP_SURR_LO     = 21'h00d800;
    localparam logic [20:0] CP_SURR_HI     = 21'h00dfff;

    // One input transaction.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic       still_valid;
        logic [2:0] error_kind;
        logic       document_done;
        logic       document_valid;
    } t_out_item;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [1:0]  bytes_pending;
        logic [20:0] code_point_accum;
        logic [1:0]  sequence_class;
        t_err        first_error;
    } t_state;

    localparam t_state STATE_RESET = '{
        bytes_pending:    2'd0,
        code_point_accum: 21'd0,
        sequence_class:   CLS_NONE,
        first_error:      ERR_NONE
    };

    // Smallest code point that a sequence of the given class may encode.
    function automatic logic [20:0] class_minimum(input logic [1:0] cls);
        logic [20:0] min_cp;
        unique case (cls)
            CLS_TWO:   min_cp = CP_MIN_TWO;
            CLS_THREE: min_cp = CP_MIN_THREE;
            default:   min_cp = CP_MIN_FOUR;
        endcase
        return min_cp;
    endfunction

endpackage

// ===== rtl/utf8_stream_validator.sv =====
// ============================================================================
// UTF-8 stream validator
// Checks a byte stream for strict UTF-8 text with a per-byte sticky status
// and a document verdict on the byte marked last.
// ============================================================================
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-----------------------
//  in      | input     | i_in_valid/o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_data (t_out_item)
//
//  One transaction is accepted every cycle while the output side keeps up.
//  Each byte passes through the input register, then the decode step into the
//  result register.
//  Reset (synchronous, active low) empties both registers and clears the
//  decoder state; it needs no clearing pass.
//  A stall on the output holds the result register, and the input stalls
//  only when the input register is full and cannot move forward.
module utf8_stream_validator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  utf8v_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output utf8v_pkg::t_out_item o_out_data
);

    logic                 r_in_valid;
    utf8v_pkg::t_in_item  r_in_data;
    logic                 r_out_valid;
    utf8v_pkg::t_out_item r_out_data;
    utf8v_pkg::t_state    r_state;
    utf8v_pkg::t_state    n_state;
    utf8v_pkg::t_out_item n_result;
    logic                 out_free;
    logic                 advance;
    logic                 in_take;

    // Pipeline flow control.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Decode step for the byte in the input register.
    utf8v_decode u_decode (
        .i_state  (r_state),
        .i_item   (r_in_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_data <= i_in_data;
        end
    end

    // Decoder state, updated as each byte moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utf8v_pkg::STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (advance) begin
            r_out_data <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/utf8v_decode.sv =====
// ============================================================================
// UTF-8 byte decoder
// Combinational step: takes the current state and one byte, and gives the
// next state and the result for that byte.
// ============================================================================
module utf8v_decode (
    input  utf8v_pkg::t_state    i_state,
    input  utf8v_pkg::t_in_item  i_item,
    output utf8v_pkg::t_state    o_state,
    output utf8v_pkg::t_out_item o_result
);

    utf8v_pkg::t_state step_state;
    utf8v_pkg::t_state end_state;
    logic [7:0]        b;
    logic [20:0]       cp_next;
    logic [1:0]        pend_next;
    logic              range_bad;

    assign b         = i_item.byte_value;
    assign cp_next   = {i_state.code_point_accum[14:0], b[5:0]};
    assign pend_next = i_state.bytes_pending - 2'd1;
    assign range_bad = (cp_next < utf8v_pkg::class_minimum(i_state.sequence_class))
                     || (cp_next > utf8v_pkg::CP_MAX)
                     || ((cp_next >= utf8v_pkg::CP_SURR_LO)
                         && (cp_next <= utf8v_pkg::CP_SURR_HI));

    // Byte decode. Any error drops the open sequence and latches the first code.
    always_comb begin
        step_state = i_state;
        if (i_state.first_error != utf8v_pkg::ERR_NONE) begin
            step_state = i_state;
        end else if (i_state.bytes_pending != 2'd0) begin
            if (b[7:6] != utf8v_pkg::CONT_TAG) begin
                step_state             = utf8v_pkg::STATE_RESET;
                step_state.first_error = utf8v_pkg::ERR_CONT;
            end else if (pend_next != 2'd0) begin
                step_state.bytes_pending    = pend_next;
                step_state.code_point_accum = cp_next;
            end else if (range_bad) begin
                step_state             = utf8v_pkg::STATE_RESET;
                step_state.first_error = utf8v_pkg::ERR_RANGE;
            end else begin
                step_state = utf8v_pkg::STATE_RESET;
            end
        end else begin
            unique case (b) inside
                [8'h00:8'h7f]: begin
                    if ((b < utf8v_pkg::BYTE_SPACE) && (b != utf8v_pkg::BYTE_TAB)
                        && (b != utf8v_pkg::BYTE_LF) && (b != utf8v_pkg::BYTE_CR)) begin
                        step_state.first_error = utf8v_pkg::ERR_CONTROL;
                    end
                end
                [8'hc2:8'hdf]: begin
                    step_state.bytes_pending    = 2'd1;
                    step_state.sequence_class   = utf8v_pkg::CLS_TWO;
                    step_state.code_point_accum = {16'd0, b[4:0]};
                end
                [8'he0:8'hef]: begin
                    step_state.bytes_pending    = 2'd2;
                    step_state.sequence_class   = utf8v_pkg::CLS_THREE;
                    step_state.code_point_accum = {17'd0, b[3:0]};
                end
                [8'hf0:8'hf4]: begin
                    step_state.bytes_pending    = 2'd3;
                    step_state.sequence_class   = utf8v_pkg::CLS_FOUR;
                    step_state.code_point_accum = {18'd0, b[2:0]};
                end
                default: begin
                    step_state             = utf8v_pkg::STATE_RESET;
                    step_state.first_error = utf8v_pkg::ERR_LEAD;
                end
            endcase
        end
    end

    // A sequence still open on the last byte is a truncation.
    always_comb begin
        end_state = step_state;
        if (i_item.last_byte && (step_state.bytes_pending != 2'd0)) begin
            end_state             = utf8v_pkg::STATE_RESET;
            end_state.first_error = utf8v_pkg::ERR_TRUNCATED;
        end
    end

    // Result for this byte; the document closes on the last byte.
    always_comb begin
        o_result.still_valid    = (end_state.first_error == utf8v_pkg::ERR_NONE);
        o_result.error_kind     = end_state.first_error;
        o_result.document_done  = i_item.last_byte;
        o_result.document_valid = i_item.last_byte
                                  && (end_state.first_error == utf8v_pkg::ERR_NONE);
        o_state = i_item.last_byte ? utf8v_pkg::STATE_RESET : end_state;
    end

endmodule
